>>> rtl/utgi_pkg.sv
// Shared types and constants for the UTF-8 to glyph index decoder.
// Used by the search cells and the top level; no dependencies.
package utgi_pkg;

    localparam int CELL_COUNT      = 32;
    localparam int CELL_BITS       = 5;
    localparam int ROW_MAX_W       = 11;
    localparam int ROWS_W          = ROW_MAX_W + 1;
    localparam int LIM_W           = 17;
    localparam int CODE_W          = 16;
    localparam int ENTRIES_W       = 11;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [1:0] KIND_FOUND   = 2'd0;
    localparam logic [1:0] KIND_MISSING = 2'd1;
    localparam logic [1:0] KIND_SPACE   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic [7:0] LEAD2_MASK   = 8'h1F;
    localparam logic [7:0] LEAD3_MASK   = 8'h0F;
    localparam logic [7:0] CONT_MASK    = 8'h3F;
    localparam logic [7:0] BYTE_ASCII   = 8'h80;
    localparam logic [7:0] BYTE_BAD_MAX = 8'hC1;
    localparam logic [7:0] BYTE_LEAD3   = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4   = 8'hF0;
    localparam logic [7:0] BYTE_BAD_MIN = 8'hF5;

    localparam logic [CODE_W-1:0] CODE_TAB     = 16'h0009;
    localparam logic [CODE_W-1:0] CODE_LF      = 16'h000A;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 16'h0020;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 16'hFFFD;

    typedef struct packed {
        logic                 vld;
        logic                 found;
        logic [CODE_W-1:0]    hit;
        logic [ROW_MAX_W-1:0] row;
    } search_tok_t;

    typedef struct packed {
        logic                 en;
        logic [CELL_BITS-1:0] bank;
        logic [ROW_MAX_W-1:0] row;
        logic [CODE_W-1:0]    code;
    } tbl_wr_t;

endpackage

>>> rtl/utgi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/utgi_cell.sv
// One search cell: a bank of the glyph code table and one token stage.
// Depends on utgi_pkg and utgi_ram.
module utgi_cell
    import utgi_pkg::*;
#(
    parameter int CELL_ID    = 0,
    parameter int BANK_DEPTH = 32,
    parameter int ROW_W      = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic [CODE_W-1:0] code,
    input  logic [LIM_W-1:0]  limit,
    input  search_tok_t       tok_in,
    output search_tok_t       tok_out
);

    localparam logic [CELL_BITS-1:0] ID_BITS = CELL_BITS'(CELL_ID);

    search_tok_t       tok_reg;
    logic [CODE_W-1:0] rdata;
    logic [LIM_W-1:0]  idx;
    logic              match;

    utgi_ram #(
        .WIDTH (CODE_W),
        .DEPTH (BANK_DEPTH),
        .AW    (ROW_W)
    ) u_bank (
        .clk   (clk),
        .we    (wr.en && (wr.bank == ID_BITS)),
        .waddr (wr.row[ROW_W-1:0]),
        .wdata (wr.code),
        .raddr (tok_in.row[ROW_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    assign idx   = LIM_W'({tok_reg.row[ROW_W-1:0], ID_BITS});
    assign match = tok_reg.vld && !tok_reg.found && (rdata == code) && (idx < limit);

    always_comb
    begin
        tok_out = tok_reg;
        if (match)
        begin
            tok_out.found = 1'b1;
            tok_out.hit   = CODE_W'(idx);
        end
    end

endmodule

>>> rtl/utf8_to_glyph_index_top.sv
// Top level of the UTF-8 to glyph index decoder: decode, search control, output.
// Depends on utgi_pkg and utgi_cell.
//
// Input channel (item_valid/item_ready): mode 0 writes entry_code into table
// slot entry_slot and gives no result; mode 1 delivers one UTF-8 text byte.
// Output channel (result_valid/result_ready): value, kind, last.
// APB register 0 (entries_in_use) sets how many table slots are searched.
// Table loads, bytes that complete no character, whitespace and searches with
// no entries in use need no lookup. A code point lookup sends one token per
// table row (32 slots per row) down a row of 32 cells, each holding one bank
// of the table; the row issue feeds each token into the 32-stage cell chain.
// The result sits in an output register; the next item is accepted once that
// register is empty or in the cycle its result is taken, and never while a
// lookup is pending. When the receiver stalls, a held result blocks every item.
// Reset clears decode state and entries_in_use; table contents stay undefined
// until written, with no clearing pass.
module utf8_to_glyph_index_top
    import utgi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 mode,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    input  logic [9:0]           entry_slot,
    input  logic [15:0]          entry_code,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [15:0]          value,
    output logic [1:0]           kind,
    output logic                 last
);

    localparam int BANK_DEPTH = (TABLE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    typedef enum logic {S_IDLE, S_SEARCH} state_t;

    state_t              state_reg,   state_next;
    logic [1:0]          pending_reg, pending_next;
    logic                skip_reg,    skip_next;
    logic [CODE_W-1:0]   partial_reg, partial_next;
    logic [ENTRIES_W-1:0] entries_reg;
    logic [CODE_W-1:0]   code_reg,    code_next;
    logic [LIM_W-1:0]    limit_reg,   limit_next;
    logic [ROWS_W-1:0]   rows_reg,    rows_next;
    logic [ROWS_W-1:0]   issue_reg,   issue_next;
    logic [ROWS_W-1:0]   exit_reg,    exit_next;
    logic                seen_reg,    seen_next;
    logic [CODE_W-1:0]   hit_reg,     hit_next;
    logic                hold_last_reg, hold_last_next;
    logic                rvalid_reg,  rvalid_next;
    logic [CODE_W-1:0]   value_reg,   value_next;
    logic [1:0]          kind_reg,    kind_next;
    logic                rlast_reg,   rlast_next;

    logic                text_fire;
    logic                load_fire;
    logic                cfg_write;
    logic                have_code;
    logic [CODE_W-1:0]   dec_code;
    logic [LIM_W-1:0]    limit_now;
    logic [LIM_W-1:0]    entries_ext;
    tbl_wr_t             tbl_wr;
    search_tok_t         chain [CELL_COUNT+1];

    assign item_ready = (state_reg == S_IDLE) && (!rvalid_reg || result_ready);
    assign text_fire  = item_valid && item_ready && mode;
    assign load_fire  = item_valid && item_ready && !mode;
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? 32'(entries_reg) : '0;

    assign entries_ext = LIM_W'(entries_reg);
    assign limit_now   = (entries_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
                                                              : entries_ext;

    always_comb
    begin
        tbl_wr.en   = load_fire && (LIM_W'(entry_slot) < LIM_W'(TABLE_DEPTH));
        tbl_wr.bank = entry_slot[CELL_BITS-1:0];
        tbl_wr.row  = ROW_MAX_W'(entry_slot >> CELL_BITS);
        tbl_wr.code = entry_code;
    end

    // issue one token per table row
    always_comb
    begin
        chain[0]       = '0;
        chain[0].vld   = (state_reg == S_SEARCH) && (issue_reg != rows_reg);
        chain[0].row   = issue_reg[ROW_MAX_W-1:0];
    end

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        utgi_cell #(
            .CELL_ID    (g),
            .BANK_DEPTH (BANK_DEPTH),
            .ROW_W      (ROW_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (tbl_wr),
            .code    (code_reg),
            .limit   (limit_reg),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // decode the text byte
    always_comb
    begin
        pending_next = pending_reg;
        skip_next    = skip_reg;
        partial_next = partial_reg;
        have_code    = 1'b0;
        dec_code     = '0;
        if (pending_reg != 2'd0)
        begin
            pending_next = pending_reg - 2'd1;
            if (!skip_reg)
            begin
                partial_next = {partial_reg[CODE_W-7:0], text_byte[5:0] & CONT_MASK[5:0]};
                if (pending_next == 2'd0)
                begin
                    have_code = 1'b1;
                    dec_code  = partial_next;
                end
            end
            if (pending_next == 2'd0)
            begin
                skip_next = 1'b0;
            end
        end
        else if (text_byte < BYTE_ASCII)
        begin
            have_code = 1'b1;
            dec_code  = CODE_W'(text_byte);
        end
        else if (text_byte > BYTE_BAD_MAX && text_byte < BYTE_LEAD3)
        begin
            partial_next = CODE_W'(text_byte & LEAD2_MASK);
            pending_next = 2'd1;
            skip_next    = 1'b0;
        end
        else if (text_byte >= BYTE_LEAD3 && text_byte < BYTE_LEAD4)
        begin
            partial_next = CODE_W'(text_byte & LEAD3_MASK);
            pending_next = 2'd2;
            skip_next    = 1'b0;
        end
        else if (text_byte >= BYTE_LEAD4 && text_byte < BYTE_BAD_MIN)
        begin
            pending_next = 2'd3;
            skip_next    = 1'b1;
        end
        if (end_of_text)
        begin
            pending_next = 2'd0;
            skip_next    = 1'b0;
            partial_next = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        limit_next     = limit_reg;
        rows_next      = rows_reg;
        issue_next     = issue_reg;
        exit_next      = exit_reg;
        seen_next      = seen_reg;
        hit_next       = hit_reg;
        hold_last_next = hold_last_reg;
        rvalid_next    = rvalid_reg && !result_ready;
        value_next     = value_reg;
        kind_next      = kind_reg;
        rlast_next     = rlast_reg;

        if (text_fire)
        begin
            if (have_code)
            begin
                if (dec_code == CODE_TAB || dec_code == CODE_LF || dec_code == CODE_SPACE)
                begin
                    rvalid_next = 1'b1;
                    value_next  = dec_code;
                    kind_next   = KIND_SPACE;
                    rlast_next  = end_of_text;
                end
                else if (limit_now == '0)
                begin
                    rvalid_next = 1'b1;
                    value_next  = CODE_UNKNOWN;
                    kind_next   = KIND_MISSING;
                    rlast_next  = end_of_text;
                end
                else
                begin
                    state_next     = S_SEARCH;
                    code_next      = dec_code;
                    limit_next     = limit_now;
                    rows_next      = ROWS_W'((limit_now + LIM_W'(CELL_COUNT - 1)) >> CELL_BITS);
                    issue_next     = '0;
                    exit_next      = '0;
                    seen_next      = 1'b0;
                    hold_last_next = end_of_text;
                end
            end
            else if (end_of_text)
            begin
                rvalid_next = 1'b1;
                value_next  = '0;
                kind_next   = KIND_END;
                rlast_next  = 1'b1;
            end
        end

        if (state_reg == S_SEARCH)
        begin
            if (issue_reg != rows_reg)
            begin
                issue_next = issue_reg + ROWS_W'(1);
            end
            if (chain[CELL_COUNT].vld)
            begin
                exit_next = exit_reg + ROWS_W'(1);
                if (chain[CELL_COUNT].found && !seen_reg)
                begin
                    seen_next = 1'b1;
                    hit_next  = chain[CELL_COUNT].hit;
                end
                if (exit_next == rows_reg)
                begin
                    state_next  = S_IDLE;
                    rvalid_next = 1'b1;
                    rlast_next  = hold_last_reg;
                    if (seen_next)
                    begin
                        value_next = hit_next;
                        kind_next  = KIND_FOUND;
                    end
                    else
                    begin
                        value_next = CODE_UNKNOWN;
                        kind_next  = KIND_MISSING;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            skip_reg      <= 1'b0;
            partial_reg   <= '0;
            entries_reg   <= '0;
            issue_reg     <= '0;
            exit_reg      <= '0;
            seen_reg      <= 1'b0;
            rvalid_reg    <= 1'b0;
            rows_reg      <= '0;
            code_reg      <= '0;
            limit_reg     <= '0;
            hit_reg       <= '0;
            hold_last_reg <= 1'b0;
            value_reg     <= '0;
            kind_reg      <= '0;
            rlast_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (text_fire)
            begin
                pending_reg <= pending_next;
                skip_reg    <= skip_next;
                partial_reg <= partial_next;
            end
            if (cfg_write)
            begin
                entries_reg <= pwdata[ENTRIES_W-1:0];
            end
            issue_reg     <= issue_next;
            exit_reg      <= exit_next;
            seen_reg      <= seen_next;
            rvalid_reg    <= rvalid_next;
            rows_reg      <= rows_next;
            code_reg      <= code_next;
            limit_reg     <= limit_next;
            hit_reg       <= hit_next;
            hold_last_reg <= hold_last_next;
            value_reg     <= value_next;
            kind_reg      <= kind_next;
            rlast_reg     <= rlast_next;
        end
    end

    assign result_valid = rvalid_reg;
    assign value        = value_reg;
    assign kind         = kind_reg;
    assign last         = rlast_reg;

    a_skip_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> pending_reg != 2'd0)
        else $error("skip set with no pending bytes");

    a_end_clears_decode: assert property (@(posedge clk) disable iff (!rst_n)
        text_fire && end_of_text |=> pending_reg == 2'd0 && !skip_reg && partial_reg == '0)
        else $error("decode state not cleared after final byte");

    a_search_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !rvalid_reg)
        else $error("output register busy during lookup");

    a_exit_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CELL_COUNT].vld |-> state_reg == S_SEARCH)
        else $error("search token left the chain outside a lookup");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) && kind_reg == KIND_FOUND && $past(state_reg) == S_SEARCH
        |-> LIM_W'(value_reg) < limit_reg)
        else $error("found index beyond searched entries");

endmodule
